// ----- rtl/round_robin_tick_scheduler_defines.svh -----
// Assertion macros used by the scheduler datapath.
`ifndef ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define RRTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
// Types, constants and codes of the round-robin tick scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int TICK_W              = 16;
   localparam int CFG_W               = 8;

   localparam logic [CFG_W-1:0] QUANTUM_RESET  = 8'd4;
   localparam logic [CFG_W-1:0] DISPATCH_RESET = 8'd0;

   // results per transaction and scheduling passes per tick
   localparam logic [1:0] RESULTS_MAX = 2'd3;
   localparam logic [1:0] ITER_LAST   = 2'd3;

   typedef enum logic {
      CSR_QUANTUM  = 1'b0,
      CSR_DISPATCH = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_ARRIVAL = 1'b0,
      REQ_TICK    = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_IDLE     = 3'd0,
      EV_DISPATCH = 3'd1,
      EV_RUNNING  = 3'd2,
      EV_EXIT     = 3'd3,
      EV_ARRIVAL  = 3'd4
   } event_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_TICK,
      ST_HEAD,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic              req_type;
      logic [TICK_W-1:0] task_id;
      logic [TICK_W-1:0] task_request;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        event_kind;
      logic [TICK_W-1:0] tick_now;
      logic [TICK_W-1:0] out_task_id;
      logic [TICK_W-1:0] ticks_used;
      logic [TICK_W-1:0] ticks_requested;
      logic [TICK_W-1:0] wait_ticks;
      logic [TICK_W-1:0] turnaround_ticks;
      logic              queue_full;
      logic              last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic [TICK_W-1:0] id;
      logic [TICK_W-1:0] req;
      logic [TICK_W-1:0] used;
      logic [TICK_W-1:0] arr;
   } queue_entry_type;

   // controller to datapath
   typedef struct packed {
      logic           load;
      logic           enqueue;
      logic           select;
      logic           deselect;
      logic           dcnt_inc;
      logic           run;
      logic           rotate;
      logic           retire;
      logic           tick_inc;
      logic           emit;
      event_kind_type kind;
      logic           flush;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_tick;
      logic queue_empty;
      logic queue_full;
      logic selected;
      logic disp_zero;
      logic dcnt_zero;
      logic dcnt_below;
      logic task_done;
      logic slice_below;
      logic pend_valid;
      logic pend_free;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/rrts_if.sv -----
// Valid/ready channel interfaces for scheduler requests and responses.
`timescale 1ns / 1ps
interface rrts_req_if import rrts_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/rrts_ctrl.sv -----
// Scheduler controller: sequences arrivals and tick passes over the datapath.
`timescale 1ns / 1ps
module rrts_ctrl import rrts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     n_ff, n_in;       // results emitted for this transaction
   logic [1:0]     iter_ff, iter_in; // scheduling pass within a tick
   logic           emit_room;
   logic           hold;
   logic           iter_done;

   // results past the cap are dropped; emitting states wait for pending room
   assign emit_room = (n_ff != RESULTS_MAX);
   assign hold      = emit_room && !status.pend_free;
   assign iter_done = (iter_ff == ITER_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_is_tick ? ST_TICK : ST_ARRIVE;
            end
         end
         ST_ARRIVE: begin
            if (!hold) begin
               state_in = ST_FINISH;
            end
         end
         ST_TICK: begin
            if (!hold) begin
               if (status.queue_empty) begin
                  state_in = ST_FINISH;
               end else if (status.disp_zero) begin
                  state_in = ST_HEAD;
               end else if (status.dcnt_below) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (!hold) begin
               if (!status.task_done && status.slice_below) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = iter_done ? ST_FINISH : ST_TICK;
               end
            end
         end
         ST_FINISH: begin
            if (!status.pend_valid || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      n_in      = n_ff;
      iter_in   = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               n_in     = 2'd0;
               iter_in  = 2'd0;
            end
         end
         ST_ARRIVE: begin
            if (!hold) begin
               cmd.emit    = emit_room;
               cmd.kind    = EV_ARRIVAL;
               cmd.enqueue = !status.queue_full;
            end
         end
         ST_TICK: begin
            if (!hold) begin
               if (status.queue_empty) begin
                  cmd.deselect = 1'b1;
                  cmd.tick_inc = 1'b1;
                  cmd.emit     = emit_room;
                  cmd.kind     = EV_IDLE;
               end else begin
                  cmd.select = !status.selected;
                  if (status.disp_zero) begin
                     // untimed dispatch report, once per selection
                     if (status.dcnt_zero) begin
                        cmd.dcnt_inc = 1'b1;
                        cmd.emit     = emit_room;
                        cmd.kind     = EV_DISPATCH;
                     end
                  end else if (status.dcnt_below) begin
                     cmd.dcnt_inc = 1'b1;
                     cmd.tick_inc = 1'b1;
                     cmd.emit     = emit_room;
                     cmd.kind     = EV_DISPATCH;
                  end
               end
            end
         end
         ST_HEAD: begin
            if (!hold) begin
               if (!status.task_done) begin
                  if (status.slice_below) begin
                     cmd.run      = 1'b1;
                     cmd.tick_inc = 1'b1;
                     cmd.emit     = emit_room;
                     cmd.kind     = EV_RUNNING;
                  end else begin
                     cmd.rotate   = 1'b1;
                     cmd.deselect = 1'b1;
                     iter_in      = iter_ff + 2'd1;
                  end
               end else begin
                  cmd.retire   = 1'b1;
                  cmd.deselect = 1'b1;
                  cmd.emit     = emit_room;
                  cmd.kind     = EV_EXIT;
                  iter_in      = iter_ff + 2'd1;
               end
            end
         end
         ST_FINISH: begin
            cmd.flush = status.pend_valid && status.out_free;
         end
         default: ;
      endcase
      if (cmd.emit) begin
         n_in = n_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= 2'd0;
         iter_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// ----- rtl/rrts_dp.sv -----
// Scheduler datapath: ready queue memory, counters, result staging.
`timescale 1ns / 1ps
`include "round_robin_tick_scheduler_defines.svh"
module rrts_dp import rrts_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  csr_index_type   csr_index,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // ready queue, one write and one registered read per cycle
   queue_entry_type mem [QUEUE_DEPTH];
   queue_entry_type rd_ff;

   req_payload_type   item_ff, item_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              selected_ff, selected_in;
   logic [CFG_W-1:0]  dcnt_ff, dcnt_in;
   logic [CFG_W-1:0]  slice_ff, slice_in;
   logic [CFG_W-1:0]  quantum_ff, quantum_in;
   logic [CFG_W-1:0]  dispatch_ff, dispatch_in;
   rsp_payload_type   pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_payload_type   out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [CFG_W-1:0]  dcnt_eff;
   logic [CFG_W-1:0]  quantum_eff;
   logic [TICK_W-1:0] req_fixed;
   logic [CNT_W:0]    tail_sum;
   logic [CNT_W:0]    tail_wrap;
   logic [IDX_W-1:0]  tail_idx;
   logic [IDX_W-1:0]  head_next;
   logic [TICK_W-1:0] tat;
   logic [TICK_W-1:0] wait_val;
   logic              out_free;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   queue_entry_type   wr_data;
   rsp_payload_type   emit_res;

   // derived values
   assign dcnt_eff    = selected_ff ? dcnt_ff : '0;
   assign quantum_eff = (quantum_ff == '0) ? CFG_W'(1) : quantum_ff;
   assign req_fixed   = (item_ff.task_request == '0) ? TICK_W'(1) : item_ff.task_request;
   assign tail_sum    = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign tail_wrap   = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                        tail_sum - (CNT_W + 1)'(QUEUE_DEPTH) : tail_sum;
   assign tail_idx    = tail_wrap[IDX_W-1:0];
   assign head_next   = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign tat         = tick_ff - rd_ff.arr;
   assign wait_val    = tat - rd_ff.req;
   assign out_free    = !out_valid_ff || rsp_ready;

   // status to the controller
   always_comb begin
      status.req_is_tick = (req_payload.req_type == REQ_TICK);
      status.queue_empty = (count_ff == '0);
      status.queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      status.selected    = selected_ff;
      status.disp_zero   = (dispatch_ff == '0);
      status.dcnt_zero   = (dcnt_eff == '0);
      status.dcnt_below  = (dcnt_eff < dispatch_ff);
      status.task_done   = (rd_ff.used >= rd_ff.req);
      status.slice_below = (slice_ff < quantum_eff);
      status.pend_valid  = pend_valid_ff;
      status.pend_free   = !pend_valid_ff || out_free;
      status.out_free    = out_free;
   end

   // result built for the event being reported
   always_comb begin
      emit_res            = '0;
      emit_res.event_kind = cmd.kind;
      emit_res.tick_now   = tick_ff;
      case (cmd.kind)
         EV_RUNNING: begin
            emit_res.out_task_id     = rd_ff.id;
            emit_res.ticks_used      = rd_ff.used;
            emit_res.ticks_requested = rd_ff.req;
         end
         EV_EXIT: begin
            emit_res.out_task_id      = rd_ff.id;
            emit_res.ticks_used       = rd_ff.used;
            emit_res.ticks_requested  = rd_ff.req;
            emit_res.wait_ticks       = wait_val;
            emit_res.turnaround_ticks = tat;
         end
         EV_ARRIVAL: begin
            emit_res.out_task_id     = item_ff.task_id;
            emit_res.ticks_requested = req_fixed;
            emit_res.queue_full      = status.queue_full;
         end
         default: ;
      endcase
   end

   // queue write port: arrival and rotation at the tail, usage update at the head
   always_comb begin
      wr_en   = cmd.enqueue || cmd.run || cmd.rotate;
      wr_addr = cmd.run ? head_ff : tail_idx;
      wr_data = rd_ff;
      if (cmd.enqueue) begin
         wr_data.id   = item_ff.task_id;
         wr_data.req  = req_fixed;
         wr_data.used = '0;
         wr_data.arr  = tick_ff;
      end else if (cmd.run) begin
         wr_data.used = rd_ff.used + TICK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[head_ff];
   end

   // scheduler state
   always_comb begin
      item_in     = cmd.load ? req_payload : item_ff;
      tick_in     = cmd.tick_inc ? tick_ff + TICK_W'(1) : tick_ff;
      head_in     = (cmd.rotate || cmd.retire) ? head_next : head_ff;
      count_in    = count_ff;
      if (cmd.enqueue) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.retire) begin
         count_in = count_ff - CNT_W'(1);
      end
      selected_in = selected_ff;
      if (cmd.select) begin
         selected_in = 1'b1;
      end else if (cmd.deselect) begin
         selected_in = 1'b0;
      end
      dcnt_in = dcnt_ff;
      if (cmd.dcnt_inc) begin
         dcnt_in = dcnt_eff + CFG_W'(1);
      end else if (cmd.select) begin
         dcnt_in = '0;
      end
      slice_in = slice_ff;
      if (cmd.run) begin
         slice_in = slice_ff + CFG_W'(1);
      end else if (cmd.select) begin
         slice_in = '0;
      end
   end

   // configuration registers
   always_comb begin
      quantum_in  = quantum_ff;
      dispatch_in = dispatch_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUANTUM:  quantum_in  = csr_wr_data;
            CSR_DISPATCH: dispatch_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // one result held back so the final one can be flagged, then the output register
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      if (rsp_ready && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_valid_in = 1'b1;
         end
         pend_in       = emit_res;
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         out_in             = pend_ff;
         out_in.last_result = 1'b1;
         out_valid_in       = 1'b1;
         pend_valid_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
      if (reset) begin
         tick_ff       <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         selected_ff   <= 1'b0;
         dcnt_ff       <= '0;
         slice_ff      <= '0;
         quantum_ff    <= QUANTUM_RESET;
         dispatch_ff   <= DISPATCH_RESET;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         tick_ff       <= tick_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         selected_ff   <= selected_in;
         dcnt_ff       <= dcnt_in;
         slice_ff      <= slice_in;
         quantum_ff    <= quantum_in;
         dispatch_ff   <= dispatch_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `RRTS_ASSERT_IMPLY(a_enqueue_has_room, clock, reset, cmd.enqueue, !status.queue_full, "enqueue into a full queue")
   `RRTS_ASSERT_IMPLY(a_retire_has_task, clock, reset, cmd.retire || cmd.rotate, !status.queue_empty, "head removed from an empty queue")
   `RRTS_ASSERT_NEXT(a_emit_pends, clock, reset, cmd.emit, pend_valid_ff, "emitted result not staged")
   `RRTS_ASSERT_NEXT(a_head_stable, clock, reset, !(cmd.rotate || cmd.retire), $stable(head_ff), "queue head moved without rotate or retire")

endmodule

// ----- rtl/round_robin_tick_scheduler.sv -----
// Top level of the round-robin tick scheduler.
`timescale 1ns / 1ps
// Round-robin scheduler stepped by transactions on req_chan: an arrival queues a task
// (up to QUEUE_DEPTH tasks) and answers with one arrival result; a tick transaction
// answers with one to three results (exit, dispatch, running or idle), the final one
// marked by last_result. One transaction is processed at a time. A tick that retires or
// rotates the head task can go on to the next one, and each head decision waits on the
// queue memory, which has a single registered read port at the head. Backpressure on
// rsp_chan stalls the scheduler; the final result sits in an output register while the
// next transaction is accepted. The queue needs no clearing pass after reset.
// Configuration is written through csr_* while no transaction is in progress; the
// user must keep to this, as the block itself does not enforce it.
module round_robin_tick_scheduler import rrts_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   rrts_req_if.sink         req_chan,
   rrts_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  csr_index_type    csr_index,
   input  logic [CFG_W-1:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrts_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

endmodule
